### hdl/lcttl_pkg.sv
package lcttl_pkg;

    // Field widths fixed by the item format.
    localparam int FUNC_W      = 3;
    localparam int KEY_W       = 32;
    localparam int VAL_W       = 32;
    localparam int TTL_W       = 32;
    localparam int TIME_W      = 48;
    localparam int OUT_CNT_W   = 7;
    localparam int CAP_W       = 7;
    localparam int ENTRIES_DEF = 64;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    // Operation codes.
    localparam logic [FUNC_W-1:0] FUNC_GET   = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_PUT   = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_DEL   = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_SWEEP = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 3'd4;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [KEY_W-1:0]  lookup_key;
        logic [VAL_W-1:0]  write_value;
        logic [TTL_W-1:0]  ttl_ms;
        logic [TIME_W-1:0] now_ms;
    } t_in_item;

    typedef struct packed {
        logic                 hit;
        logic [VAL_W-1:0]     read_value;
        logic [OUT_CNT_W-1:0] occupancy;
        logic [OUT_CNT_W-1:0] evicted_count;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND,
        S_ADJ,
        S_PUTNEW,
        S_CLR,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        M_REMOVE,
        M_TOUCH,
        M_TOUCHW
    } t_adj_mode;

endpackage

### hdl/lcttl_mem.sv
module lcttl_mem #(
    parameter int DEPTH  = 64,
    parameter int WIDTH  = 8,
    parameter int ADDR_W = 6
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;

endmodule

### hdl/lcttl_engine.sv
module lcttl_engine #(
    parameter int ENTRIES = lcttl_pkg::ENTRIES_DEF,
    parameter int ADDR_W  = $clog2(ENTRIES),
    parameter int CNT_W   = $clog2(ENTRIES + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  lcttl_pkg::t_in_item  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output lcttl_pkg::t_out_item o_out_data,
    input  logic [CNT_W-1:0]     i_limit
);

    localparam int RANK_W = ADDR_W;
    localparam int EW     = 1 + lcttl_pkg::KEY_W + lcttl_pkg::VAL_W + lcttl_pkg::TIME_W + RANK_W;

    lcttl_pkg::t_state    r_state, n_state;
    lcttl_pkg::t_adj_mode r_mode, n_mode;

    logic [CNT_W-1:0]             r_cnt, n_cnt;
    logic [lcttl_pkg::FUNC_W-1:0] r_func, n_func;
    logic [lcttl_pkg::KEY_W-1:0]  r_key, n_key;
    logic [lcttl_pkg::VAL_W-1:0]  r_val, n_val;
    logic [lcttl_pkg::TIME_W-1:0] r_exp, n_exp;
    logic [lcttl_pkg::TIME_W-1:0] r_now, n_now;
    logic [CNT_W-1:0]             r_count, n_count;
    logic [CNT_W-1:0]             r_evict, n_evict;
    logic                         r_found, n_found;
    logic [ADDR_W-1:0]            r_fidx, n_fidx;
    logic [RANK_W-1:0]            r_frank, n_frank;
    logic [lcttl_pkg::VAL_W-1:0]  r_fval, n_fval;
    logic                         r_fexpd, n_fexpd;
    logic                         r_hit, n_hit;
    logic [lcttl_pkg::VAL_W-1:0]  r_rval, n_rval;
    logic                         r_placed, n_placed;
    logic                         r_init, n_init;
    logic                         r_out_valid, n_out_valid;
    lcttl_pkg::t_out_item         r_out, n_out;

    logic                         proc, last;
    logic [ADDR_W-1:0]            proc_addr, rd_addr;
    logic [EW-1:0]                mem_q, wr_data;
    logic                         wr_en;
    logic                         q_valid, q_expd, q_evict;
    logic [lcttl_pkg::KEY_W-1:0]  q_key;
    logic [lcttl_pkg::VAL_W-1:0]  q_val;
    logic [lcttl_pkg::TIME_W-1:0] q_exp;
    logic [RANK_W-1:0]            q_rank;
    logic [lcttl_pkg::TIME_W:0]   exp_sum;
    logic [lcttl_pkg::TIME_W-1:0] exp_new;

    // Pass counter: read address c is issued while entry c-1 is processed.
    assign proc      = (r_cnt != '0);
    assign last      = (r_cnt == CNT_W'(ENTRIES));
    assign proc_addr = ADDR_W'(r_cnt - CNT_W'(1));
    assign rd_addr   = last ? '0 : r_cnt[ADDR_W-1:0];

    lcttl_mem #(
        .DEPTH  (ENTRIES),
        .WIDTH  (EW),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (proc_addr),
        .i_wdata (wr_data),
        .i_raddr (rd_addr),
        .o_rdata (mem_q)
    );

    // Unpack the entry read on the previous cycle.
    assign q_valid = mem_q[EW-1];
    assign q_key   = mem_q[EW-2 -: lcttl_pkg::KEY_W];
    assign q_val   = mem_q[EW-2-lcttl_pkg::KEY_W -: lcttl_pkg::VAL_W];
    assign q_exp   = mem_q[RANK_W +: lcttl_pkg::TIME_W];
    assign q_rank  = mem_q[RANK_W-1:0];
    assign q_expd  = (q_exp != '0) && (q_exp < r_now);
    assign q_evict = q_valid && (CNT_W'(q_rank) >= (i_limit - CNT_W'(1)));

    // Expiry of a put: now plus ttl, saturating, zero ttl meaning permanent.
    assign exp_sum = {1'b0, i_in_data.now_ms}
                   + (lcttl_pkg::TIME_W + 1)'(i_in_data.ttl_ms);
    always_comb begin
        if (i_in_data.ttl_ms == '0) begin
            exp_new = '0;
        end else if (exp_sum[lcttl_pkg::TIME_W]) begin
            exp_new = '1;
        end else begin
            exp_new = exp_sum[lcttl_pkg::TIME_W-1:0];
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lcttl_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    case (i_in_data.func) inside
                        lcttl_pkg::FUNC_GET, lcttl_pkg::FUNC_PUT,
                        lcttl_pkg::FUNC_DEL, lcttl_pkg::FUNC_SWEEP: n_state = lcttl_pkg::S_FIND;
                        lcttl_pkg::FUNC_CLEAR: n_state = lcttl_pkg::S_CLR;
                        default: n_state = lcttl_pkg::S_DONE;
                    endcase
                end
            end
            lcttl_pkg::S_FIND: begin
                if (last) begin
                    if (n_found) begin
                        n_state = lcttl_pkg::S_ADJ;
                    end else if (r_func == lcttl_pkg::FUNC_PUT) begin
                        n_state = lcttl_pkg::S_PUTNEW;
                    end else begin
                        n_state = lcttl_pkg::S_DONE;
                    end
                end
            end
            lcttl_pkg::S_ADJ: begin
                if (last) begin
                    n_state = (r_func == lcttl_pkg::FUNC_SWEEP) ? lcttl_pkg::S_FIND
                                                                : lcttl_pkg::S_DONE;
                end
            end
            lcttl_pkg::S_PUTNEW: begin
                if (last) begin
                    n_state = lcttl_pkg::S_DONE;
                end
            end
            lcttl_pkg::S_CLR: begin
                if (last) begin
                    n_state = r_init ? lcttl_pkg::S_IDLE : lcttl_pkg::S_DONE;
                end
            end
            lcttl_pkg::S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_state = lcttl_pkg::S_IDLE;
                end
            end
            default: n_state = lcttl_pkg::S_IDLE;
        endcase
    end

    // Datapath and memory writes.
    always_comb begin
        n_cnt       = r_cnt;
        n_mode      = r_mode;
        n_func      = r_func;
        n_key       = r_key;
        n_val       = r_val;
        n_exp       = r_exp;
        n_now       = r_now;
        n_count     = r_count;
        n_evict     = r_evict;
        n_found     = r_found;
        n_fidx      = r_fidx;
        n_frank     = r_frank;
        n_fval      = r_fval;
        n_fexpd     = r_fexpd;
        n_hit       = r_hit;
        n_rval      = r_rval;
        n_placed    = r_placed;
        n_init      = r_init;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        wr_en       = 1'b0;
        wr_data     = mem_q;
        unique case (r_state)
            lcttl_pkg::S_IDLE: begin
                n_cnt = '0;
                if (i_in_valid) begin
                    n_func   = i_in_data.func;
                    n_key    = i_in_data.lookup_key;
                    n_val    = i_in_data.write_value;
                    n_now    = i_in_data.now_ms;
                    n_exp    = exp_new;
                    n_found  = 1'b0;
                    n_evict  = '0;
                    n_hit    = 1'b0;
                    n_rval   = '0;
                    n_placed = 1'b0;
                end
            end
            lcttl_pkg::S_FIND: begin
                n_cnt = r_cnt + CNT_W'(1);
                if (proc && !r_found && q_valid &&
                    ((r_func == lcttl_pkg::FUNC_SWEEP) ? q_expd : (q_key == r_key))) begin
                    n_found = 1'b1;
                    n_fidx  = proc_addr;
                    n_frank = q_rank;
                    n_fval  = q_val;
                    n_fexpd = q_expd;
                end
                if (last) begin
                    n_cnt = '0;
                    if (n_found) begin
                        case (r_func)
                            lcttl_pkg::FUNC_GET: begin
                                if (n_fexpd) begin
                                    n_mode  = lcttl_pkg::M_REMOVE;
                                    n_evict = r_evict + CNT_W'(1);
                                end else begin
                                    n_mode = lcttl_pkg::M_TOUCH;
                                    n_hit  = 1'b1;
                                    n_rval = n_fval;
                                end
                            end
                            lcttl_pkg::FUNC_PUT: begin
                                n_mode = lcttl_pkg::M_TOUCHW;
                                n_hit  = 1'b1;
                            end
                            lcttl_pkg::FUNC_DEL: begin
                                n_mode = lcttl_pkg::M_REMOVE;
                                n_hit  = 1'b1;
                            end
                            default: begin
                                n_mode  = lcttl_pkg::M_REMOVE;
                                n_evict = r_evict + CNT_W'(1);
                            end
                        endcase
                    end
                end
            end
            lcttl_pkg::S_ADJ: begin
                n_cnt = r_cnt + CNT_W'(1);
                if (proc) begin
                    wr_en = 1'b1;
                    if (proc_addr == r_fidx) begin
                        if (r_mode == lcttl_pkg::M_REMOVE) begin
                            wr_data[EW-1] = 1'b0;
                        end else begin
                            wr_data[RANK_W-1:0] = '0;
                            if (r_mode == lcttl_pkg::M_TOUCHW) begin
                                wr_data[EW-2-lcttl_pkg::KEY_W -: lcttl_pkg::VAL_W] = r_val;
                                wr_data[RANK_W +: lcttl_pkg::TIME_W] = r_exp;
                            end
                        end
                    end else if (q_valid) begin
                        if (r_mode == lcttl_pkg::M_REMOVE) begin
                            if (q_rank > r_frank) begin
                                wr_data[RANK_W-1:0] = q_rank - RANK_W'(1);
                            end
                        end else if (q_rank < r_frank) begin
                            wr_data[RANK_W-1:0] = q_rank + RANK_W'(1);
                        end
                    end
                end
                if (last) begin
                    n_cnt   = '0;
                    n_found = 1'b0;
                    if (r_mode == lcttl_pkg::M_REMOVE) begin
                        n_count = r_count - CNT_W'(1);
                    end
                end
            end
            lcttl_pkg::S_PUTNEW: begin
                n_cnt = r_cnt + CNT_W'(1);
                if (proc) begin
                    wr_en = 1'b1;
                    if (q_evict) begin
                        n_evict = r_evict + CNT_W'(1);
                    end
                    if (q_valid && !q_evict) begin
                        wr_data[RANK_W-1:0] = q_rank + RANK_W'(1);
                    end else if (!r_placed) begin
                        // The lowest free slot takes the new key as most recent.
                        n_placed = 1'b1;
                        wr_data  = {1'b1, r_key, r_val, r_exp, {RANK_W{1'b0}}};
                    end else begin
                        wr_data[EW-1] = 1'b0;
                    end
                end
                if (last) begin
                    n_cnt   = '0;
                    n_count = r_count - n_evict + CNT_W'(1);
                end
            end
            lcttl_pkg::S_CLR: begin
                n_cnt = r_cnt + CNT_W'(1);
                if (proc) begin
                    wr_en   = 1'b1;
                    wr_data = '0;
                end
                if (last) begin
                    n_cnt   = '0;
                    n_count = '0;
                    n_init  = 1'b0;
                end
            end
            lcttl_pkg::S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid         = 1'b1;
                    n_out.hit           = r_hit;
                    n_out.read_value    = r_rval;
                    n_out.occupancy     = lcttl_pkg::OUT_CNT_W'(r_count);
                    n_out.evicted_count = lcttl_pkg::OUT_CNT_W'(r_evict);
                end
            end
            default: begin
                n_cnt = '0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lcttl_pkg::S_CLR;
            r_cnt       <= '0;
            r_count     <= '0;
            r_init      <= 1'b1;
            r_out_valid <= 1'b0;
            r_found     <= 1'b0;
            r_placed    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_count     <= n_count;
            r_init      <= n_init;
            r_out_valid <= n_out_valid;
            r_found     <= n_found;
            r_placed    <= n_placed;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_mode  <= n_mode;
        r_func  <= n_func;
        r_key   <= n_key;
        r_val   <= n_val;
        r_exp   <= n_exp;
        r_now   <= n_now;
        r_evict <= n_evict;
        r_fidx  <= n_fidx;
        r_frank <= n_frank;
        r_fval  <= n_fval;
        r_fexpd <= n_fexpd;
        r_hit   <= n_hit;
        r_rval  <= n_rval;
        r_out   <= n_out;
    end

    assign o_in_stall  = (r_state != lcttl_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // The occupancy never exceeds the table size.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(ENTRIES))
        else $error("occupancy above table size");

    // Memory writes happen only while an entry is being processed.
    a_write_in_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> proc)
        else $error("memory write outside a pass");

    // An accepted transaction always starts work.
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state != lcttl_pkg::S_IDLE))
        else $error("accepted transaction dropped");

    // The adjust pass only runs on a located entry.
    a_adj_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lcttl_pkg::S_ADJ) |-> r_found)
        else $error("adjust pass without a located entry");

endmodule

### hdl/lru_cache_with_ttl_top.sv
// Each transaction takes whole passes over the entry memory, one entry a cycle: a get, put or
// delete that finds its key a find then an adjust pass, a new key's put a find then an insert
// pass, a missed get or delete or a clear one pass, an unused code none, and a sweep turns of
// find and adjust passes until a find meets no expired entry. One transaction is in progress
// at a time, since the entry memory is read one entry a cycle; a full output register holds
// off the next. Reset is synchronous and active low: a clearing pass, capacity back to 64.
module lru_cache_with_ttl_top #(
    parameter int ENTRIES = lcttl_pkg::ENTRIES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  lcttl_pkg::t_in_item           i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output lcttl_pkg::t_out_item          o_out_data,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [lcttl_pkg::CAP_W-1:0]   i_cfg_data
);

    localparam int CNT_W = $clog2(ENTRIES + 1);

    logic [lcttl_pkg::CAP_W-1:0] r_cap;
    logic [CNT_W-1:0]            limit;

    // Capacity limit register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= lcttl_pkg::CAP_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_cap <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;

    // Zero or an oversize limit means the whole table.
    assign limit = ((r_cap == '0) || (int'(r_cap) > ENTRIES)) ? CNT_W'(ENTRIES)
                                                             : CNT_W'(r_cap);

    lcttl_engine #(
        .ENTRIES (ENTRIES)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_limit     (limit)
    );

endmodule
